>>> sv/mhsd_pkg.sv
// Package for the heap sorter: field widths, default sizes and the microcode ROM.
// Depends on nothing; the interfaces, the record store and the top level import it.
package mhsd_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;
  localparam int IN_KEY_W        = 32;
  localparam int OUT_KEY_W       = 32;
  localparam int TAG_W           = 6;
  localparam int UPC_W           = 5;

  typedef logic [UPC_W-1:0] upc_t;

  // Datapath operation performed in a step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_BINIT,
    OP_BSTEP,
    OP_XINIT,
    OP_HOLD_CUR,
    OP_XSTEP,
    OP_BEST_INIT,
    OP_CMP_LC,
    OP_CMP_RC,
    OP_DESCEND,
    OP_EINIT,
    OP_EMIT,
    OP_CLEAR
  } dp_op_t;

  // Read address source.
  typedef enum logic [2:0] {
    RD_NODE,
    RD_LC,
    RD_RC,
    RD_ROOT,
    RD_LASTI,
    RD_EMIT
  } rd_sel_t;

  // Write port source.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_IN,
    WR_NODE_BEST,
    WR_BEST_CUR,
    WR_ROOT_RD,
    WR_LASTI_CUR
  } wr_sel_t;

  // Jump condition; when it holds the sequencer goes to the target, else to the next step.
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_LAST,
    COND_I_NZ,
    COND_I_LE1,
    COND_LC_OUT,
    COND_RC_OUT,
    COND_BEST_NODE,
    COND_BUILD,
    COND_OUT_BUSY,
    COND_I_LT_N
  } cond_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd;
    wr_sel_t wr;
    cond_t   cond;
    upc_t    target;
  } ucode_t;

  // Step addresses.
  localparam upc_t U_LOAD  = 5'd0;
  localparam upc_t U_BINIT = 5'd1;
  localparam upc_t U_BLOOP = 5'd2;
  localparam upc_t U_XINIT = 5'd3;
  localparam upc_t U_XLOOP = 5'd4;
  localparam upc_t U_X1    = 5'd5;
  localparam upc_t U_X2    = 5'd6;
  localparam upc_t U_X3    = 5'd7;
  localparam upc_t U_SF0   = 5'd8;
  localparam upc_t U_SF1   = 5'd9;
  localparam upc_t U_SFLC  = 5'd10;
  localparam upc_t U_SF3   = 5'd11;
  localparam upc_t U_SF4   = 5'd12;
  localparam upc_t U_SFDEC = 5'd13;
  localparam upc_t U_SF5   = 5'd14;
  localparam upc_t U_SF6   = 5'd15;
  localparam upc_t U_SFEND = 5'd16;
  localparam upc_t U_SFRET = 5'd17;
  localparam upc_t U_EINIT = 5'd18;
  localparam upc_t U_E0    = 5'd19;
  localparam upc_t U_E1    = 5'd20;
  localparam upc_t U_E2    = 5'd21;
  localparam upc_t U_EDONE = 5'd22;

  // The control program. Sift-down is shared by heap build and extraction and
  // returns by the phase flag.
  function automatic ucode_t ucode_rom(input upc_t upc);
    ucode_t w;
    w = '{op: OP_NONE, rd: RD_NODE, wr: WR_NONE, cond: COND_NEVER, target: U_LOAD};
    unique case (upc)
      U_LOAD:  w = '{OP_TAKE,      RD_NODE,  WR_IN,        COND_NOT_LAST,  U_LOAD};
      U_BINIT: w = '{OP_BINIT,     RD_NODE,  WR_NONE,      COND_NEVER,     U_LOAD};
      U_BLOOP: w = '{OP_BSTEP,     RD_NODE,  WR_NONE,      COND_I_NZ,      U_SF0};
      U_XINIT: w = '{OP_XINIT,     RD_NODE,  WR_NONE,      COND_ALWAYS,    U_XLOOP};
      U_XLOOP: w = '{OP_NONE,      RD_ROOT,  WR_NONE,      COND_I_LE1,     U_EINIT};
      U_X1:    w = '{OP_HOLD_CUR,  RD_LASTI, WR_NONE,      COND_NEVER,     U_LOAD};
      U_X2:    w = '{OP_NONE,      RD_NODE,  WR_ROOT_RD,   COND_NEVER,     U_LOAD};
      U_X3:    w = '{OP_XSTEP,     RD_NODE,  WR_LASTI_CUR, COND_NEVER,     U_LOAD};
      U_SF0:   w = '{OP_NONE,      RD_NODE,  WR_NONE,      COND_NEVER,     U_LOAD};
      U_SF1:   w = '{OP_HOLD_CUR,  RD_NODE,  WR_NONE,      COND_NEVER,     U_LOAD};
      U_SFLC:  w = '{OP_BEST_INIT, RD_LC,    WR_NONE,      COND_LC_OUT,    U_SFEND};
      U_SF3:   w = '{OP_CMP_LC,    RD_RC,    WR_NONE,      COND_RC_OUT,    U_SFDEC};
      U_SF4:   w = '{OP_CMP_RC,    RD_NODE,  WR_NONE,      COND_NEVER,     U_LOAD};
      U_SFDEC: w = '{OP_NONE,      RD_NODE,  WR_NONE,      COND_BEST_NODE, U_SFEND};
      U_SF5:   w = '{OP_NONE,      RD_NODE,  WR_NODE_BEST, COND_NEVER,     U_LOAD};
      U_SF6:   w = '{OP_DESCEND,   RD_NODE,  WR_BEST_CUR,  COND_ALWAYS,    U_SFLC};
      U_SFEND: w = '{OP_NONE,      RD_NODE,  WR_NONE,      COND_BUILD,     U_BLOOP};
      U_SFRET: w = '{OP_NONE,      RD_NODE,  WR_NONE,      COND_ALWAYS,    U_XLOOP};
      U_EINIT: w = '{OP_EINIT,     RD_NODE,  WR_NONE,      COND_NEVER,     U_LOAD};
      U_E0:    w = '{OP_NONE,      RD_EMIT,  WR_NONE,      COND_NEVER,     U_LOAD};
      U_E1:    w = '{OP_EMIT,      RD_EMIT,  WR_NONE,      COND_OUT_BUSY,  U_E1};
      U_E2:    w = '{OP_NONE,      RD_NODE,  WR_NONE,      COND_I_LT_N,    U_E0};
      U_EDONE: w = '{OP_CLEAR,     RD_NODE,  WR_NONE,      COND_ALWAYS,    U_LOAD};
      default: w = '{OP_NONE,      RD_NODE,  WR_NONE,      COND_ALWAYS,    U_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> sv/mhsd_if.sv
// Handshake interfaces for the heap sorter's input and result channels.
// Depends on mhsd_pkg for the field widths.
interface mhsd_in_if import mhsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IN_KEY_W-1:0] sort_key;
  logic [TAG_W-1:0]    record_tag;
  logic                last_item;

  modport source(output valid, sort_key, record_tag, last_item, input ready);
  modport sink(input valid, sort_key, record_tag, last_item, output ready);
endinterface

interface mhsd_out_if import mhsd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_KEY_W-1:0] out_key;
  logic [TAG_W-1:0]     out_tag;
  logic                 out_last;

  modport source(output valid, out_key, out_tag, out_last, input ready);
  modport sink(input valid, out_key, out_tag, out_last, output ready);
endinterface

>>> sv/mhsd_store.sv
// Record store: one write port and one read port with registered read data.
// Depends on mhsd_pkg for default sizes.
module mhsd_store import mhsd_pkg::*; #(
  parameter int DEPTH = MAX_RECORDS_DEF,
  parameter int WIDTH = KEY_BITS_DEF + TAG_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/min_heap_sort_descending.sv
// Heap sorter top level: microcode sequencer, datapath and output register.
// Depends on mhsd_pkg, the interfaces in mhsd_if.sv and mhsd_store.
//
//   Channel   Modport        Word carries                      Transfer
//   in_ch     mhsd_in_if     sort_key, record_tag, last_item   valid && ready
//   out_ch    mhsd_out_if    out_key, out_tag, out_last        valid && ready
//
// Loading takes one cycle per word; the last word starts the sort.
// A sift-down level that swaps costs up to six steps (two child reads, the decision and
// two writes), the level where it stops up to four, and each sift call up to four steps
// to enter and leave; each extraction adds four steps and each sorted word a read, an
// emit and a loop-test step, all bound by the single read port of the record store.
// Reset is synchronous and active low; no clearing pass is needed since only written
// entries are ever read. Input is not ready during sort and emission; a stalled output
// holds the sequencer in its emit step.
module min_heap_sort_descending import mhsd_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mhsd_in_if.sink      in_ch,
  mhsd_out_if.source   out_ch
);

  localparam int AW    = $clog2(MAX_RECORDS);
  localparam int CW    = $clog2(MAX_RECORDS + 1);
  localparam int CHW   = AW + 2;
  localparam int REC_W = KEY_BITS + TAG_W;

  // Sequencer state.
  upc_t   upc_r, upc_nxt;
  ucode_t uw;
  logic   jump;

  // Datapath registers.
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       live_r, live_nxt;
  logic [AW-1:0]       node_r, node_nxt;
  logic [AW-1:0]       best_a_r, best_a_nxt;
  logic                build_r, build_nxt;
  logic [KEY_BITS-1:0] cur_k_r, cur_k_nxt;
  logic [TAG_W-1:0]    cur_t_r, cur_t_nxt;
  logic [KEY_BITS-1:0] best_k_r, best_k_nxt;
  logic [TAG_W-1:0]    best_t_r, best_t_nxt;

  // Output register.
  logic                 ov_r, ov_nxt;
  logic [OUT_KEY_W-1:0] ok_r, ok_nxt;
  logic [TAG_W-1:0]     ot_r, ot_nxt;
  logic                 ol_r, ol_nxt;

  // Store connections.
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [REC_W-1:0]  wr_data;
  logic [AW-1:0]     rd_addr;
  logic [REC_W-1:0]  rd_data;
  logic [KEY_BITS-1:0] rd_key;
  logic [TAG_W-1:0]    rd_tag;

  logic [CW-1:0]  i_dec;
  logic [AW-1:0]  i_dec_a;
  logic [CHW-1:0] lc;
  logic [CHW-1:0] rc;
  logic [CHW-1:0] live_ext;
  logic           in_take;
  logic           has_room;
  logic           out_busy;

  assign uw       = ucode_rom(upc_r);
  assign rd_key   = rd_data[REC_W-1:TAG_W];
  assign rd_tag   = rd_data[TAG_W-1:0];
  assign i_dec    = i_r - CW'(1);
  assign i_dec_a  = i_dec[AW-1:0];
  assign lc       = {1'b0, node_r, 1'b1};
  assign rc       = lc + CHW'(1);
  assign live_ext = CHW'(live_r);
  assign has_room = cnt_r < CW'(MAX_RECORDS);
  assign out_busy = ov_r && !out_ch.ready;

  // The input is open only in the load step.
  assign in_ch.ready = (uw.op == OP_TAKE);
  assign in_take     = in_ch.valid && in_ch.ready;

  assign out_ch.valid    = ov_r;
  assign out_ch.out_key  = ok_r;
  assign out_ch.out_tag  = ot_r;
  assign out_ch.out_last = ol_r;

  // Jump condition of the current step.
  always_comb begin
    unique case (uw.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NOT_LAST:  jump = !(in_ch.valid && in_ch.last_item);
      COND_I_NZ:      jump = (i_r != '0);
      COND_I_LE1:     jump = (i_r <= CW'(1));
      COND_LC_OUT:    jump = (lc >= live_ext);
      COND_RC_OUT:    jump = (rc >= live_ext);
      COND_BEST_NODE: jump = (best_a_r == node_r);
      COND_BUILD:     jump = build_r;
      COND_OUT_BUSY:  jump = out_busy;
      COND_I_LT_N:    jump = (i_r < cnt_r);
      default:        jump = 1'b1;
    endcase
    upc_nxt = jump ? uw.target : upc_r + UPC_W'(1);
  end

  // Read address.
  always_comb begin
    unique case (uw.rd)
      RD_NODE:  rd_addr = node_r;
      RD_LC:    rd_addr = lc[AW-1:0];
      RD_RC:    rd_addr = rc[AW-1:0];
      RD_ROOT:  rd_addr = '0;
      RD_LASTI: rd_addr = i_dec_a;
      RD_EMIT:  rd_addr = i_r[AW-1:0];
      default:  rd_addr = node_r;
    endcase
  end

  // Write port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node_r;
    wr_data = {cur_k_r, cur_t_r};
    unique case (uw.wr)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_IN: begin
        // A record beyond the store's depth is dropped.
        wr_en   = in_take && has_room;
        wr_addr = cnt_r[AW-1:0];
        wr_data = {KEY_BITS'(in_ch.sort_key), in_ch.record_tag};
      end
      WR_NODE_BEST: begin
        wr_en   = 1'b1;
        wr_addr = node_r;
        wr_data = {best_k_r, best_t_r};
      end
      WR_BEST_CUR: begin
        wr_en   = 1'b1;
        wr_addr = best_a_r;
        wr_data = {cur_k_r, cur_t_r};
      end
      WR_ROOT_RD: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = rd_data;
      end
      WR_LASTI_CUR: begin
        wr_en   = 1'b1;
        wr_addr = i_dec_a;
        wr_data = {cur_k_r, cur_t_r};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Datapath operation of the current step.
  always_comb begin
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    live_nxt   = live_r;
    node_nxt   = node_r;
    best_a_nxt = best_a_r;
    build_nxt  = build_r;
    cur_k_nxt  = cur_k_r;
    cur_t_nxt  = cur_t_r;
    best_k_nxt = best_k_r;
    best_t_nxt = best_t_r;
    ok_nxt     = ok_r;
    ot_nxt     = ot_r;
    ol_nxt     = ol_r;
    ov_nxt     = ov_r && !out_ch.ready;
    unique case (uw.op)
      OP_NONE: begin
        cnt_nxt = cnt_r;
      end
      OP_TAKE: begin
        if (in_take && has_room) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      OP_BINIT: begin
        live_nxt  = cnt_r;
        i_nxt     = cnt_r >> 1;
        build_nxt = 1'b1;
      end
      OP_BSTEP: begin
        // Next subtree root of the heap build, from the middle toward the root.
        i_nxt    = i_dec;
        node_nxt = i_dec_a;
      end
      OP_XINIT: begin
        i_nxt     = cnt_r;
        build_nxt = 1'b0;
      end
      OP_HOLD_CUR: begin
        cur_k_nxt = rd_key;
        cur_t_nxt = rd_tag;
      end
      OP_XSTEP: begin
        i_nxt    = i_dec;
        live_nxt = i_dec;
        node_nxt = '0;
      end
      OP_BEST_INIT: begin
        best_k_nxt = cur_k_r;
        best_t_nxt = cur_t_r;
        best_a_nxt = node_r;
      end
      OP_CMP_LC: begin
        // Strict less-than keeps the parent on ties.
        if (rd_key < best_k_r) begin
          best_k_nxt = rd_key;
          best_t_nxt = rd_tag;
          best_a_nxt = lc[AW-1:0];
        end
      end
      OP_CMP_RC: begin
        if (rd_key < best_k_r) begin
          best_k_nxt = rd_key;
          best_t_nxt = rd_tag;
          best_a_nxt = rc[AW-1:0];
        end
      end
      OP_DESCEND: begin
        node_nxt = best_a_r;
      end
      OP_EINIT: begin
        i_nxt = '0;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          ov_nxt = 1'b1;
          ok_nxt = OUT_KEY_W'(rd_key);
          ot_nxt = rd_tag;
          ol_nxt = ((i_r + CW'(1)) == cnt_r);
          i_nxt  = i_r + CW'(1);
        end
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r   <= U_LOAD;
      cnt_r   <= '0;
      build_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      upc_r   <= upc_nxt;
      cnt_r   <= cnt_nxt;
      build_r <= build_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    live_r   <= live_nxt;
    node_r   <= node_nxt;
    best_a_r <= best_a_nxt;
    cur_k_r  <= cur_k_nxt;
    cur_t_r  <= cur_t_nxt;
    best_k_r <= best_k_nxt;
    best_t_r <= best_t_nxt;
    ok_r     <= ok_nxt;
    ot_r     <= ot_nxt;
    ol_r     <= ol_nxt;
  end

  mhsd_store #(
    .DEPTH (MAX_RECORDS),
    .WIDTH (REC_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

>>> sv/mhsd_checker.sv
// Port-level checks for the heap sorter, attached to the top level by bind.
// Depends on mhsd_pkg for field widths and on min_heap_sort_descending.
module mhsd_checker import mhsd_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_last_item,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_KEY_W-1:0] out_key,
  input logic [TAG_W-1:0]     out_tag,
  input logic                 out_last
);

  // A stalled result word keeps its place and its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_tag)
      && $stable(out_last))
    else $error("result word changed while stalled");

  // Taking the last word of a set closes the input right after it.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_item |=> !in_ready)
    else $error("input still open after the last word");

  // While a run is still being emitted the input stays closed.
  a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open in the middle of a sorted run");

  // New result words are produced only by the emit phase, never while loading.
  a_no_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word appeared during loading");

endmodule

bind min_heap_sort_descending mhsd_checker u_mhsd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_last_item (in_ch.last_item),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_key      (out_ch.out_key),
  .out_tag      (out_ch.out_tag),
  .out_last     (out_ch.out_last)
);

>>> bench/mhsd_sort_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the heap sorter: watches both channels, sorts every loaded set with the
// block's own comparison order and checks each result word. Needs mhsd_pkg and mhsd_if.sv.
module mhsd_sort_checker import mhsd_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mhsd_in_if   in_mon,
  mhsd_out_if  out_mon,
  output int   fail_count,
  output int   words_owed
);

  typedef struct {
    logic [OUT_KEY_W-1:0] key;
    logic [TAG_W-1:0]     tag;
    logic                 last;
  } sorted_word_t;

  logic [KEY_BITS-1:0] set_key [MAX_RECORDS];
  logic [TAG_W-1:0]    set_tag [MAX_RECORDS];
  int                  set_count = 0;
  sorted_word_t        sorted_q [$];
  int                  errors = 0;

  task automatic swap_records(input int p, input int q);
    logic [KEY_BITS-1:0] k;
    logic [TAG_W-1:0]    t;
    k = set_key[p];
    t = set_tag[p];
    set_key[p] = set_key[q];
    set_tag[p] = set_tag[q];
    set_key[q] = k;
    set_tag[q] = t;
  endtask

  // Strict less-than, left child first, so ties land exactly where the block puts them.
  task automatic sift_record(input int live, input int node);
    int least;
    int lc;
    int rc;
    bit settled;
    settled = 1'b0;
    while (!settled) begin
      least = node;
      lc    = 2 * node + 1;
      rc    = 2 * node + 2;
      if (lc < live && set_key[lc] < set_key[least]) least = lc;
      if (rc < live && set_key[rc] < set_key[least]) least = rc;
      if (least == node) begin
        settled = 1'b1;
      end else begin
        swap_records(node, least);
        node = least;
      end
    end
  endtask

  task automatic sort_and_queue_set();
    sorted_word_t w;
    for (int i = set_count / 2; i > 0; i--) sift_record(set_count, i - 1);
    for (int i = set_count; i > 1; i--) begin
      swap_records(0, i - 1);
      sift_record(i - 1, 0);
    end
    for (int k = 0; k < set_count; k++) begin
      w.key  = OUT_KEY_W'(set_key[k]);
      w.tag  = set_tag[k];
      w.last = (k == set_count - 1);
      sorted_q.push_back(w);
    end
    set_count = 0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    sorted_word_t want;
    if (rst_n) begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (sorted_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual key %0h tag %0h last %0b",
                   $time, out_mon.out_key, out_mon.out_tag, out_mon.out_last);
        end else begin
          want = sorted_q.pop_front();
          check_field("out_key", 64'(want.key), 64'(out_mon.out_key));
          check_field("out_tag", 64'(want.tag), 64'(out_mon.out_tag));
          check_field("out_last", 64'(want.last), 64'(out_mon.out_last));
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        // A full store drops the record, but its last mark still starts the sort.
        if (set_count < MAX_RECORDS) begin
          set_key[set_count] = KEY_BITS'(in_mon.sort_key);
          set_tag[set_count] = in_mon.record_tag;
          set_count++;
        end
        if (in_mon.last_item) sort_and_queue_set();
      end
    end
    fail_count <= errors;
    words_owed <= sorted_q.size();
  end

endmodule

>>> bench/min_heap_sort_descending_tb.sv
`timescale 1ns / 100ps
// Top of the heap sorter bench: clock, reset, stimulus and the verdict.
// Needs mhsd_pkg, mhsd_if.sv, the sorter and mhsd_sort_checker.
module min_heap_sort_descending_tb;
  import mhsd_pkg::*;

  // Random words to send after the directed part.
  localparam int RANDOM_WORDS  = 500;
  // Quiet cycles at the end, meant to cover the sort and emission of a full 64-record set,
  // so that any stray word has time to show up.
  localparam int DRAIN_CYCLES  = 4000;
  // The clock period is 12 ns; this limit allows several times the worst case.
  localparam int TIME_LIMIT_NS = 8_000_000;

  // Shapes of the keys in one random set.
  typedef enum int {
    KEYS_WIDE,
    KEYS_TIED,
    KEYS_EDGE,
    KEYS_CLUSTERED
  } key_shape_t;

  logic clk;
  logic rst_n;
  logic sink_ready = 1'b0;
  logic calm       = 1'b0;
  int   sink_hold  = 0;
  int   fail_count;
  int   words_owed;
  int   words_sent = 0;
  int   random_base;
  int   set_index;

  mhsd_in_if  in_ch ();
  mhsd_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  min_heap_sort_descending DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mhsd_sort_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .words_owed (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long stretch.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // The result side holds each ready level for a random time. In a calm set it simply
  // stays ready once the current hold runs out.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (calm) begin
      sink_ready <= 1'b1;
    end else begin
      sink_ready <= ($urandom_range(0, 2) != 0);
      sink_hold  <= gap_len();
    end
  end

  // Presents one word and returns at the edge where it is taken. A gap before the word
  // lowers valid once; back-to-back words keep valid high throughout.
  task automatic send_word(input logic [IN_KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                           input logic last);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sort_key   <= key;
    in_ch.record_tag <= tag;
    in_ch.last_item  <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    words_sent++;
  endtask

  // Stops sending until every predicted word has come back. The checker's count is
  // registered, so the task lets it update before it reads it.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
  endtask

  // One set of random records; the final one carries the last mark. Sets longer than the
  // store end on a dropped record, which must still start the sort.
  task automatic send_random_set(input int size);
    key_shape_t          shape;
    logic [IN_KEY_W-1:0] key;
    shape = key_shape_t'($urandom_range(0, 3));
    for (int k = 0; k < size; k++) begin
      case (shape)
        KEYS_WIDE: begin
          key = $urandom();
        end
        KEYS_TIED: begin
          key = $urandom_range(0, 3);
        end
        KEYS_EDGE: begin
          case ($urandom_range(0, 3))
            0:       key = '0;
            1:       key = '1;
            2:       key = 32'h8000_0000;
            default: key = 32'h7FFF_FFFF;
          endcase
        end
        default: begin
          key = {3'($urandom_range(0, 7)), 29'($urandom())};
        end
      endcase
      send_word(key, TAG_W'($urandom_range(0, (1 << TAG_W) - 1)), k == size - 1);
    end
  endtask

  // Mostly short sets keep the sort cheap; a few fill the store or overflow it.
  function automatic int pick_set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 10);
    if (r < 90) return $urandom_range(11, 40);
    if (r < 96) return $urandom_range(41, MAX_RECORDS_DEF);
    return $urandom_range(MAX_RECORDS_DEF + 1, MAX_RECORDS_DEF + 6);
  endfunction

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.sort_key   <= '0;
    in_ch.record_tag <= '0;
    in_ch.last_item  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Single records at both extremes of key and tag.
    send_word('1, 6'd63, 1'b1);
    wait_drained();
    send_word('0, 6'd0, 1'b1);
    wait_drained();

    // Two equal keys: the tie order follows the heap, not the arrival order.
    send_word(32'h0000_1234, 6'd1, 1'b0);
    send_word(32'h0000_1234, 6'd2, 1'b1);
    wait_drained();

    // Smallest, largest and the top bit alone.
    send_word('0, 6'd3, 1'b0);
    send_word('1, 6'd4, 1'b0);
    send_word(32'h8000_0000, 6'd5, 1'b1);
    wait_drained();

    // A set of identical keys.
    for (int k = 0; k < 5; k++) send_word(32'd5, 6'(10 + k), k == 4);
    wait_drained();

    // Already ascending, then already descending.
    for (int k = 0; k < 6; k++) send_word(32'(k + 1), 6'(20 + k), k == 5);
    wait_drained();
    for (int k = 0; k < 4; k++) send_word(32'hF000_0000 - 32'(k), 6'(40 + k), k == 3);
    wait_drained();

    // Random sets. The first one fills the store exactly and the second overflows it.
    random_base = words_sent;
    set_index   = 0;
    while (words_sent - random_base < RANDOM_WORDS) begin
      calm <= ($urandom_range(0, 4) == 0);
      if (set_index == 0)
        send_random_set(MAX_RECORDS_DEF);
      else if (set_index == 1)
        send_random_set(MAX_RECORDS_DEF + 3);
      else
        send_random_set(pick_set_size());
      if ($urandom_range(0, 99) < 15) wait_drained();
      set_index++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_owed == 0) begin
      $display("min_heap_sort_descending_tb: done, clean");
    end else begin
      $display("min_heap_sort_descending_tb: done, errors");
    end
    $finish;
  end

  // A hung handshake or a missing word ends up here.
  initial begin
    #(TIME_LIMIT_NS);
    $display("min_heap_sort_descending_tb: done, errors");
    $finish;
  end

endmodule

>>> min_heap_sort_descending.f
sv/mhsd_pkg.sv
sv/mhsd_if.sv
sv/mhsd_store.sv
sv/min_heap_sort_descending.sv
sv/mhsd_checker.sv
bench/mhsd_sort_checker.sv
bench/min_heap_sort_descending_tb.sv
